FILE: src/pt4w_pkg.sv
// ----------------------------------------------------------------------------
// pt4w_pkg: shared types and constants for the four-level page table walker
// Holds command and result codes, the classified item that travels from the
// front stage to the walk engine, and the address masks of the walk.
// ----------------------------------------------------------------------------
package pt4w_pkg;

  localparam int unsigned LIN_W   = 48;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned LEVEL_W = 2;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // leaf frame bits of an entry (bits 58..12)
  localparam logic [DATA_W-1:0] LEAF_ADDR_MASK = 64'h07FF_FFFF_FFFF_F000;

  // input command codes
  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_READ_DATA = 1'b1
  } cmd_e_t;

  // result kind codes
  typedef enum logic {
    KIND_READ_REQ = 1'b0,
    KIND_DONE     = 1'b1
  } kind_e_t;

  // walk levels, top table first
  typedef enum logic [LEVEL_W-1:0] {
    LVL_PML4 = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } level_e_t;

  // one classified input beat
  typedef struct packed {
    cmd_e_t              cmd;
    logic                present;    // entry bit 0
    logic                page_size;  // entry bit 7
    logic [LIN_W-1:0]    lin;
    logic [DATA_W-1:0]   entry;
  } item_t;

endpackage

FILE: src/pt4w_front.sv
// ----------------------------------------------------------------------------
// pt4w_front: input stage of the walker
// Accepts one beat per cycle, decodes command and entry flags into an item,
// and hands it to the queue. Stalls only while its item cannot enter the queue.
// ----------------------------------------------------------------------------
module pt4w_front import pt4w_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [LIN_W-1:0]  in_linear_address,
  input  logic [DATA_W-1:0] in_read_data,
  output logic              push,
  output item_t             push_item,
  input  logic              q_full
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  // hold the item while the queue is full
  assign in_stall  = valid_r & q_full;
  assign accept    = in_valid & ~in_stall;
  assign push      = valid_r & ~q_full;
  assign push_item = item_r;
  assign valid_nxt = (valid_r & ~push) | accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // classify the beat as it is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd       <= cmd_e_t'(in_command);
      item_r.present   <= in_read_data[0];
      item_r.page_size <= in_read_data[7];
      item_r.lin       <= in_linear_address;
      item_r.entry     <= in_read_data;
    end
  end

endmodule

FILE: src/pt4w_fifo.sv
// ----------------------------------------------------------------------------
// pt4w_fifo: short item queue between front stage and walk engine
// Flop-based circular buffer; the head item is visible while not empty.
// ----------------------------------------------------------------------------
module pt4w_fifo import pt4w_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign push_ok   = push & ~full;
  assign pop_ok    = pop & ~empty;
  assign head_item = mem_r[rd_ptr_r];

  // advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store the pushed item
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: src/pt4w_back.sv
// ----------------------------------------------------------------------------
// pt4w_back: walk engine
// Takes one queued item per cycle while the output is free, steps the walk
// state, loads the output register, and drops items that cause no result.
// ----------------------------------------------------------------------------
module pt4w_back import pt4w_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  input  logic              q_empty,
  input  item_t             head_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [DATA_W-1:0] out_address,
  output logic              out_fault
);

  logic [DATA_W-1:0] root_base_r;
  logic              busy_r, busy_nxt;
  level_e_t          level_r, level_nxt;
  logic [LIN_W-1:0]  saved_lin_r, saved_lin_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_e_t           out_kind_r, out_kind_nxt;
  logic [DATA_W-1:0] out_addr_r, out_addr_nxt;
  logic              out_fault_r, out_fault_nxt;

  logic              out_free;
  logic              emit;
  level_e_t          next_level;
  logic [IDX_W-1:0]  next_idx;
  logic [IDX_W-1:0]  top_idx;
  logic [DATA_W-1:0] leaf_offset;
  logic              is_leaf;
  logic [DATA_W-1:0] leaf_addr;

  assign out_free = ~out_valid_r | ~out_stall;
  assign pop      = ~q_empty & out_free;

  // table index of the level below the current one
  assign next_level = level_e_t'(level_r + 1'b1);
  assign top_idx    = head_item.lin[47:39];

  always_comb begin
    unique case (next_level)
      LVL_PML4: next_idx = saved_lin_r[47:39];
      LVL_PDPT: next_idx = saved_lin_r[38:30];
      LVL_PD:   next_idx = saved_lin_r[29:21];
      LVL_PT:   next_idx = saved_lin_r[20:12];
      default:  next_idx = saved_lin_r[20:12];
    endcase
  end

  // leaf decode: page size by level and the page size bit
  always_comb begin
    is_leaf     = 1'b0;
    leaf_offset = '0;
    unique case (level_r)
      LVL_PDPT: begin
        if (head_item.page_size) begin
          is_leaf     = 1'b1;
          leaf_offset = {{(DATA_W-30){1'b0}}, saved_lin_r[29:0]};
        end
      end
      LVL_PD: begin
        if (head_item.page_size) begin
          is_leaf     = 1'b1;
          leaf_offset = {{(DATA_W-21){1'b0}}, saved_lin_r[20:0]};
        end
      end
      LVL_PT: begin
        is_leaf     = 1'b1;
        leaf_offset = {{(DATA_W-12){1'b0}}, saved_lin_r[11:0]};
      end
      default: begin
        is_leaf     = 1'b0;
        leaf_offset = '0;
      end
    endcase
  end

  assign leaf_addr = (head_item.entry & LEAF_ADDR_MASK) + leaf_offset;

  // step the walk for the head item
  always_comb begin
    busy_nxt      = busy_r;
    level_nxt     = level_r;
    saved_lin_nxt = saved_lin_r;
    emit          = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_fault_nxt = out_fault_r;
    if (pop) begin
      unique case (head_item.cmd)
        CMD_TRANSLATE: begin
          if (!busy_r) begin
            busy_nxt      = 1'b1;
            level_nxt     = LVL_PML4;
            saved_lin_nxt = head_item.lin;
            emit          = 1'b1;
            out_kind_nxt  = KIND_READ_REQ;
            out_addr_nxt  = {root_base_r[DATA_W-1:12], top_idx, 3'b000};
            out_fault_nxt = 1'b0;
          end
        end
        CMD_READ_DATA: begin
          if (busy_r) begin
            emit = 1'b1;
            if (!head_item.present) begin
              busy_nxt      = 1'b0;
              level_nxt     = LVL_PML4;
              out_kind_nxt  = KIND_DONE;
              out_addr_nxt  = '0;
              out_fault_nxt = 1'b1;
            end else if (is_leaf) begin
              busy_nxt      = 1'b0;
              level_nxt     = LVL_PML4;
              out_kind_nxt  = KIND_DONE;
              out_addr_nxt  = leaf_addr;
              out_fault_nxt = 1'b0;
            end else begin
              level_nxt     = next_level;
              out_kind_nxt  = KIND_READ_REQ;
              out_addr_nxt  = {head_item.entry[DATA_W-1:12], next_idx, 3'b000};
              out_fault_nxt = 1'b0;
            end
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  // keep a waiting result, load a new one, or drop the slot once taken
  assign out_valid_nxt = emit | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_base_r <= '0;
      busy_r      <= 1'b0;
      level_r     <= LVL_PML4;
      saved_lin_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        root_base_r <= cfg_wr_data;
      end
      busy_r      <= busy_nxt;
      level_r     <= level_nxt;
      saved_lin_r <= saved_lin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= out_kind_nxt;
      out_addr_r  <= out_addr_nxt;
      out_fault_r <= out_fault_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_address = out_addr_r;
  assign out_fault   = out_fault_r;

endmodule

FILE: src/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker: 48-bit four-level page table walker
//
//   channel | direction | handshake           | beat contents
//   in      | input     | in_valid / in_stall | command, linear address, read data
//   out     | output    | out_valid/out_stall | kind, address, fault
//   cfg     | input     | cfg_wr_en           | root table base
//
// Takes one beat per cycle unless stalled; each beat passes the front
// register, then a queue entry, then the walk engine and its output register.
// Beats that cause no result (request while walking, data while idle) are
// dropped in the walk engine after they pass through the queue.
// Reset is synchronous and clears the walk state, the queue and the root base.
// An output stall fills the queue first; the input stalls once it is full.
// ----------------------------------------------------------------------------
module four_level_page_table_walker import pt4w_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [LIN_W-1:0]  in_linear_address,
  input  logic [DATA_W-1:0] in_read_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [DATA_W-1:0] out_address,
  output logic              out_fault
);

  logic  push, q_full, q_empty, pop;
  item_t push_item, head_item;

  // decode and register input beats
  pt4w_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_linear_address(in_linear_address),
    .in_read_data     (in_read_data),
    .push             (push),
    .push_item        (push_item),
    .q_full           (q_full)
  );

  // decouple front and walk engine
  pt4w_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head_item(head_item)
  );

  // walk state and result register
  pt4w_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_empty    (q_empty),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_address(out_address),
    .out_fault  (out_fault)
  );

endmodule

FILE: src/pt4w_checker.sv
// ----------------------------------------------------------------------------
// pt4w_checker: port-level checks for the page table walker
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module pt4w_checker import pt4w_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_kind,
  input logic [DATA_W-1:0] out_address,
  input logic              out_fault
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_address) && $stable(out_fault))
    else $error("result beat changed while stalled");

  // a fault ends the walk with a zero address
  a_fault_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_kind == KIND_DONE && out_address == '0)
    else $error("fault beat with bad kind or address");

  // a read request names an aligned 8-byte entry
  a_req_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_READ_REQ |-> out_address[2:0] == 3'b000 && !out_fault)
    else $error("read request misaligned or flagged");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind four_level_page_table_walker pt4w_checker u_checker (.*);

FILE: verif/walk_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// walk_result_checker: result predictor and scoreboard for the page walker
// Watches the root base writes and the beats that cross the input and result
// channels, walks its own copy of the four-level tables state for every
// accepted input beat, and compares each result beat field by field with the
// oldest expected one. The top level reads the mismatch and backlog counts.
// ----------------------------------------------------------------------------
module walk_result_checker import pt4w_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_command,
  input  logic [LIN_W-1:0]  in_linear_address,
  input  logic [DATA_W-1:0] in_read_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_kind,
  input  logic [DATA_W-1:0] out_address,
  input  logic              out_fault,
  output int                mismatch_count,
  output int                checked_count,
  output int                outstanding
);

  localparam int unsigned       REPORT_LIMIT   = 10;
  localparam logic [DATA_W-1:0] OFFSET_1G_MASK = (64'd1 << 30) - 64'd1;
  localparam logic [DATA_W-1:0] OFFSET_2M_MASK = (64'd1 << 21) - 64'd1;
  localparam logic [DATA_W-1:0] OFFSET_4K_MASK = (64'd1 << 12) - 64'd1;

  typedef struct packed {
    kind_e_t           kind;
    logic [DATA_W-1:0] address;
    logic              fault;
  } walk_result_t;

  walk_result_t         expected_results[$];
  logic                 walk_active;
  logic [LEVEL_W-1:0]   walk_depth;
  logic [LIN_W-1:0]     latched_linear;
  logic [DATA_W-1:0]    root_base;

  // entry address: table base on a 4K boundary plus 8 bytes per index
  function automatic logic [DATA_W-1:0] table_slot(input logic [DATA_W-1:0] base,
                                                   input logic [LIN_W-1:0]  lin,
                                                   input logic [LEVEL_W-1:0] depth);
    logic [IDX_W-1:0] slot;
    slot = IDX_W'(lin >> (39 - 9 * depth));
    return {base[DATA_W-1:12], slot, 3'b000};
  endfunction

  // advance the walk by one accepted beat and queue the result it causes
  task automatic advance_walk(input logic              cmd,
                              input logic [LIN_W-1:0]  lin,
                              input logic [DATA_W-1:0] entry);
    walk_result_t      beat;
    logic [DATA_W-1:0] offset_mask;
    beat.kind    = KIND_READ_REQ;
    beat.address = '0;
    beat.fault   = 1'b0;
    offset_mask  = '0;
    if (cmd == CMD_TRANSLATE) begin
      // drop a request while a walk is open
      if (!walk_active) begin
        latched_linear = lin;
        walk_depth     = LVL_PML4;
        walk_active    = 1'b1;
        beat.address   = table_slot(root_base, lin, LVL_PML4);
        expected_results.push_back(beat);
      end
    end else if (walk_active) begin
      if (!entry[0]) begin
        // not-present entry ends the walk
        walk_active = 1'b0;
        walk_depth  = LVL_PML4;
        beat.kind   = KIND_DONE;
        beat.fault  = 1'b1;
      end else begin
        if (walk_depth == LVL_PDPT && entry[7])
          offset_mask = OFFSET_1G_MASK;
        else if (walk_depth == LVL_PD && entry[7])
          offset_mask = OFFSET_2M_MASK;
        else if (walk_depth == LVL_PT)
          offset_mask = OFFSET_4K_MASK;
        if (offset_mask != '0) begin
          walk_active  = 1'b0;
          walk_depth   = LVL_PML4;
          beat.kind    = KIND_DONE;
          beat.address = (entry & LEAF_ADDR_MASK) +
                         ({{(DATA_W-LIN_W){1'b0}}, latched_linear} & offset_mask);
        end else begin
          // descend one level, the entry is the next table base
          walk_depth   = walk_depth + 1'b1;
          beat.address = table_slot(entry, latched_linear, walk_depth);
        end
      end
      expected_results.push_back(beat);
    end
  endtask

  always @(posedge clk) begin : watch
    walk_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      walk_active    = 1'b0;
      walk_depth     = LVL_PML4;
      latched_linear = '0;
      root_base      = '0;
      mismatch_count = 0;
      checked_count  = 0;
    end else begin
      if (cfg_wr_en)
        root_base = cfg_wr_data;
      // check the result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("ERROR %0t: result beat with nothing expected: kind=%0d address=%h fault=%0d",
                     $realtime, out_kind, out_address, out_fault);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (out_kind !== want.kind || out_address !== want.address ||
              out_fault !== want.fault) begin
            if (mismatch_count < REPORT_LIMIT)
              $display({"ERROR %0t: expected kind=%0d address=%h fault=%0d, ",
                        "got kind=%0d address=%h fault=%0d"}, $realtime,
                       want.kind, want.address, want.fault,
                       out_kind, out_address, out_fault);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        advance_walk(in_command, in_linear_address, in_read_data);
    end
    outstanding <= expected_results.size();
  end

endmodule

FILE: verif/four_level_page_table_walker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_test: stimulus and verdict for the page walker
// Drives directed walks over the corner cases, then phases of random walks
// under several root table bases with random idling on both channels. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_test;
  import pt4w_pkg::*;

  localparam int ITEM_TARGET   = 750;
  localparam int PHASES        = 6;
  localparam int IDLE_PCT      = 34;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [DATA_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic              in_command;
  logic [LIN_W-1:0]  in_linear_address;
  logic [DATA_W-1:0] in_read_data;
  logic              out_valid;
  logic              out_stall;
  logic              out_kind;
  logic [DATA_W-1:0] out_address;
  logic              out_fault;

  int mismatch_count;
  int checked_count;
  int outstanding;
  int idle_pct = IDLE_PCT;
  int beats_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  four_level_page_table_walker DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_linear_address (in_linear_address),
    .in_read_data      (in_read_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_address       (out_address),
    .out_fault         (out_fault)
  );

  walk_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_linear_address (in_linear_address),
    .in_read_data      (in_read_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_address       (out_address),
    .out_fault         (out_fault),
    .mismatch_count    (mismatch_count),
    .checked_count     (checked_count),
    .outstanding       (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // random back-pressure on the result channel
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // offer one beat after a random gap, hold it until it is taken
  task automatic send_beat(input cmd_e_t            cmd,
                           input logic [DATA_W-1:0] lin,
                           input logic [DATA_W-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_linear_address <= lin[LIN_W-1:0];
    in_read_data      <= data;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // hold the input until every expected result is out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_root(input logic [DATA_W-1:0] base);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  // one walk: a request, then entries until the walk ends, with some noise
  task automatic run_walk();
    logic [DATA_W-1:0] entry;
    logic              scrambled;
    logic              fault_end;
    logic              done;
    int                stop_level;
    int                pick;
    int                depth;
    scrambled  = ($urandom_range(99) < 15);
    pick       = $urandom_range(99);
    fault_end  = (pick < 20);
    stop_level = fault_end ? $urandom_range(3) :
                 (pick < 40) ? LVL_PDPT : (pick < 60) ? LVL_PD : LVL_PT;
    // stray read data while idle is dropped
    if ($urandom_range(99) < 6)
      send_beat(CMD_READ_DATA, rand64(), rand64());
    send_beat(CMD_TRANSLATE, rand64(), rand64());
    beats_sent++;
    done  = 1'b0;
    depth = 0;
    while (!done) begin
      // a request during the walk is dropped
      if ($urandom_range(99) < 8)
        send_beat(CMD_TRANSLATE, rand64(), rand64());
      entry = rand64();
      if (!scrambled) begin
        entry[0] = !(fault_end && depth == stop_level);
        if (depth == LVL_PDPT || depth == LVL_PD)
          entry[7] = !fault_end && depth == stop_level;
      end
      send_beat(CMD_READ_DATA, rand64(), entry);
      beats_sent++;
      done = !entry[0] || depth == LVL_PT ||
             (entry[7] && (depth == LVL_PDPT || depth == LVL_PD));
      depth++;
    end
  endtask

  initial begin
    int phase;
    logic [DATA_W-1:0] base;
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_valid          <= 1'b0;
    in_command        <= CMD_TRANSLATE;
    in_linear_address <= '0;
    in_read_data      <= '0;
    out_stall         <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed walks under the all-ones root base
    write_root(ALL_ONES);
    // 1G leaf, with bit 7 of the top entry not taken as a leaf
    send_beat(CMD_TRANSLATE, '1, '0);
    send_beat(CMD_READ_DATA, '0, ALL_ONES);
    send_beat(CMD_READ_DATA, '1, ALL_ONES);
    // 2M leaf at the zero address
    send_beat(CMD_TRANSLATE, '0, ALL_ONES);
    send_beat(CMD_READ_DATA, '0, 64'h1);
    send_beat(CMD_READ_DATA, '0, 64'h1);
    send_beat(CMD_READ_DATA, '0, 64'h81);
    // not-present top entry
    send_beat(CMD_TRANSLATE, rand64(), rand64());
    send_beat(CMD_READ_DATA, rand64(), 64'h0);
    // not-present third-level entry with every other bit set
    send_beat(CMD_TRANSLATE, rand64(), rand64());
    send_beat(CMD_READ_DATA, rand64(), 64'h1);
    send_beat(CMD_READ_DATA, rand64(), 64'h8000_0000_0000_0001);
    send_beat(CMD_READ_DATA, rand64(), 64'hFFFF_FFFF_FFFF_FFFE);
    // data while idle and a request while busy are dropped
    send_beat(CMD_READ_DATA, rand64(), ALL_ONES);
    send_beat(CMD_TRANSLATE, rand64(), rand64());
    send_beat(CMD_TRANSLATE, rand64(), rand64());
    send_beat(CMD_READ_DATA, rand64(), 64'hFFFF_FFFF_FFFF_FF7F);
    send_beat(CMD_READ_DATA, rand64(), 64'h0);
    // 4K leaf with bit 7 set in the last entry
    send_beat(CMD_TRANSLATE, rand64(), rand64());
    send_beat(CMD_READ_DATA, rand64(), 64'h1);
    send_beat(CMD_READ_DATA, rand64(), 64'h1);
    send_beat(CMD_READ_DATA, rand64(), 64'h0000_0000_0000_0F01);
    send_beat(CMD_READ_DATA, rand64(), ALL_ONES);
    beats_sent += 20;

    // random phases, one root base each; phase 2 runs with no idling
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: base = '0;
        2: base = ALL_ONES;
        3: base = 64'h0000_0000_0000_0FFF;
        default: base = rand64();
      endcase
      settle();
      write_root(base);
      idle_pct = (phase == 2) ? 0 : IDLE_PCT;
      while (beats_sent < 20 + (phase + 1) * ITEM_TARGET / PHASES) begin
        run_walk();
        // in phase 1, pause the sender mid-phase until all results are back
        if (phase == 1 && beats_sent >= 20 + 3 * ITEM_TARGET / (2 * PHASES) &&
            beats_sent < 20 + 3 * ITEM_TARGET / (2 * PHASES) + 5)
          settle();
      end
    end
    idle_pct = IDLE_PCT;
    settle();

    $display("Run covered %0d walk beats under %0d root table bases, %0d results checked.",
             beats_sent, settings_used, checked_count);
    $display("Mismatching result beats: %0d, still expected: %0d.",
             mismatch_count, outstanding);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/pt4w_pkg.sv
src/pt4w_front.sv
src/pt4w_fifo.sv
src/pt4w_back.sv
src/four_level_page_table_walker.sv
src/pt4w_checker.sv
verif/walk_result_checker.sv
verif/four_level_page_table_walker_test.sv
